[rtl/ssrc_pkg.sv]
`timescale 1ns / 1ps

package ssrc_pkg;

   // field widths of the channels and registers
   localparam int SPAN_WORD_W  = 16;
   localparam int DST_W        = 12;
   localparam int SRC_OFFSET_W = 20;
   localparam int RUN_LENGTH_W = 11;
   localparam int CSR_DATA_W   = 11;
   localparam int CSR_INDEX_W  = 3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPRITE_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPRITE_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_POS_X         = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_POS_Y         = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_ENABLE   = 3'd6;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] RST_SCREEN_WIDTH  = 11'd320;
   localparam logic [CSR_DATA_W-1:0] RST_SCREEN_HEIGHT = 11'd240;
   localparam logic [CSR_DATA_W-1:0] RST_SPRITE_WIDTH  = 11'd1;
   localparam logic [CSR_DATA_W-1:0] RST_SPRITE_HEIGHT = 11'd1;
   localparam logic [CSR_DATA_W-1:0] RST_POS_X         = 11'd0;
   localparam logic [CSR_DATA_W-1:0] RST_POS_Y         = 11'd0;
   localparam logic                  RST_CLIP_ENABLE   = 1'b1;

   // longest run that leaves the block unclipped
   localparam int LEN_MAX = 2047;

   typedef logic [SPAN_WORD_W-1:0]  span_word_type;
   typedef logic [DST_W-1:0]        dst_type;
   typedef logic [SRC_OFFSET_W-1:0] src_offset_type;
   typedef logic [RUN_LENGTH_W-1:0] run_length_type;

endpackage

[rtl/ssrc_if.sv]
`timescale 1ns / 1ps

interface ssrc_req_if;
   import ssrc_pkg::*;

   logic          valid;
   logic          ready;
   span_word_type span_word;

   modport source (output valid, output span_word, input ready);
   modport sink   (input valid, input span_word, output ready);
endinterface

interface ssrc_rsp_if;
   import ssrc_pkg::*;

   logic           valid;
   logic           ready;
   dst_type        dst_x;
   dst_type        dst_y;
   src_offset_type src_offset;
   run_length_type run_length;

   modport source (output valid, output dst_x, output dst_y, output src_offset,
                   output run_length, input ready);
   modport sink   (input valid, input dst_x, input dst_y, input src_offset,
                   input run_length, output ready);
endinterface

[rtl/sprite_span_run_clipper.sv]
`timescale 1ns / 1ps

// Walks a run-length coded sprite one span word per beat: a row start flag, alternating
// opaque/transparent run lengths, then a zero word closing the row. Each opaque run gives one
// result beat with its screen position, source pixel offset and length, cut to the screen
// window when clip_enable is set; runs clipped away, transparent runs, flags and row ends give
// nothing. Sustained rate is one span word per clock; a word goes through an input register
// and the run math into the result register, and only a stalled result register holds the
// input side. Write the registers only while no beat is in flight.
module sprite_span_run_clipper #(
   parameter int MAX_DIMENSION = 1024,
   parameter int SPAN_BITS     = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   ssrc_req_if.sink                          req_span,
   ssrc_rsp_if.source                        rsp_run,
   input  logic                              csr_write_enable,
   input  logic [ssrc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ssrc_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import ssrc_pkg::*;

   localparam int COL_W = $clog2(2 * MAX_DIMENSION);
   localparam int ROW_W = $clog2(MAX_DIMENSION);
   localparam int NW    = (ROW_W + 1 > CSR_DATA_W) ? ROW_W + 1 : CSR_DATA_W;
   localparam int AW0   = (SPAN_BITS > COL_W) ? SPAN_BITS : COL_W;
   localparam int AW    = ((AW0 > CSR_DATA_W) ? AW0 : CSR_DATA_W) + 2;
   localparam logic [AW-1:0] COL_MAX = AW'(2 * MAX_DIMENSION - 1);
   localparam logic [NW-1:0] ROW_LIMIT = NW'(MAX_DIMENSION);

   // configuration registers
   logic [CSR_DATA_W-1:0] screen_width_ff, screen_height_ff;
   logic [CSR_DATA_W-1:0] sprite_width_ff, sprite_height_ff;
   logic [CSR_DATA_W-1:0] pos_x_ff, pos_y_ff;
   logic                  clip_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= RST_SCREEN_WIDTH;
         screen_height_ff <= RST_SCREEN_HEIGHT;
         sprite_width_ff  <= RST_SPRITE_WIDTH;
         sprite_height_ff <= RST_SPRITE_HEIGHT;
         pos_x_ff         <= RST_POS_X;
         pos_y_ff         <= RST_POS_Y;
         clip_enable_ff   <= RST_CLIP_ENABLE;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_write_data;
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_write_data;
            CSR_SPRITE_WIDTH:  sprite_width_ff  <= csr_write_data;
            CSR_SPRITE_HEIGHT: sprite_height_ff <= csr_write_data;
            CSR_POS_X:         pos_x_ff         <= csr_write_data;
            CSR_POS_Y:         pos_y_ff         <= csr_write_data;
            CSR_CLIP_ENABLE:   clip_enable_ff   <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // input register
   logic                 in_valid_ff;
   logic [SPAN_BITS-1:0] word_ff;
   logic                 out_valid_ff;
   logic                 advance;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_run.ready);
   assign req_span.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_span.ready) begin
         in_valid_ff <= req_span.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_span.ready && req_span.valid) begin
         word_ff <= req_span.span_word[SPAN_BITS-1:0];
      end
   end

   // walk state
   logic                    expect_ff, opaque_ff;
   logic [COL_W-1:0]        col_ff;
   logic [ROW_W-1:0]        row_ff;
   logic [SRC_OFFSET_W-1:0] base_ff;

   logic                    expect_in, opaque_in;
   logic [COL_W-1:0]        col_in;
   logic [ROW_W-1:0]        row_in;
   logic [SRC_OFFSET_W-1:0] base_in;

   // run math
   logic signed [AW-1:0] px, py, c_ext, w_ext, r_ext, sw_ext, sh_ext, spw_ext;
   logic signed [AW-1:0] x, y, lo, hi, a, b, clip_len, a_off;
   logic [AW-1:0]        col_sum;
   logic [NW-1:0]        row_next;
   logic                 word_zero, y_visible, emit;

   dst_type        dst_x_in, dst_y_in;
   src_offset_type src_in;
   run_length_type len_in;

   always_comb begin
      px      = {{(AW-CSR_DATA_W){pos_x_ff[CSR_DATA_W-1]}}, pos_x_ff};
      py      = {{(AW-CSR_DATA_W){pos_y_ff[CSR_DATA_W-1]}}, pos_y_ff};
      c_ext   = {{(AW-COL_W){1'b0}}, col_ff};
      w_ext   = {{(AW-SPAN_BITS){1'b0}}, word_ff};
      r_ext   = {{(AW-ROW_W){1'b0}}, row_ff};
      sw_ext  = {{(AW-CSR_DATA_W){1'b0}}, screen_width_ff};
      sh_ext  = {{(AW-CSR_DATA_W){1'b0}}, screen_height_ff};
      spw_ext = {{(AW-CSR_DATA_W){1'b0}}, sprite_width_ff};

      x  = px + c_ext;
      y  = py + r_ext;
      lo = px[AW-1] ? '0 : px;
      hi = px + spw_ext;
      if (hi > sw_ext) begin
         hi = sw_ext;
      end
      a = (x > lo) ? x : lo;
      b = x + w_ext;
      if (b > hi) begin
         b = hi;
      end
      clip_len  = b - a;
      a_off     = a - x;
      y_visible = !y[AW-1] && (y < sh_ext);
      word_zero = (word_ff == '0);

      emit = 1'b0;
      if (!expect_ff && !word_zero && opaque_ff) begin
         emit = !clip_enable_ff || (y_visible && (a < b));
      end

      // unclipped run keeps its position and saturates its length
      if (!clip_enable_ff) begin
         dst_x_in = x[DST_W-1:0];
         src_in   = base_ff + {{(SRC_OFFSET_W-COL_W){1'b0}}, col_ff};
         len_in   = (w_ext > AW'(LEN_MAX)) ? RUN_LENGTH_W'(LEN_MAX)
                                          : w_ext[RUN_LENGTH_W-1:0];
      end else begin
         dst_x_in = a[DST_W-1:0];
         src_in   = base_ff + {{(SRC_OFFSET_W-COL_W){1'b0}}, col_ff}
                    + {{(SRC_OFFSET_W-AW){1'b0}}, a_off};
         len_in   = clip_len[RUN_LENGTH_W-1:0];
      end
      dst_y_in = y[DST_W-1:0];

      col_sum  = c_ext + w_ext;
      row_next = {{(NW-ROW_W){1'b0}}, row_ff} + NW'(1);

      expect_in = expect_ff;
      opaque_in = opaque_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      base_in   = base_ff;
      if (expect_ff) begin
         opaque_in = (word_ff == SPAN_BITS'(1));
         col_in    = '0;
         expect_in = 1'b0;
      end else if (word_zero) begin
         if (row_next >= {{(NW-CSR_DATA_W){1'b0}}, sprite_height_ff}
             || row_next >= ROW_LIMIT) begin
            row_in  = '0;
            base_in = '0;
         end else begin
            row_in  = row_next[ROW_W-1:0];
            base_in = base_ff + {{(SRC_OFFSET_W-CSR_DATA_W){1'b0}}, sprite_width_ff};
         end
         expect_in = 1'b1;
      end else begin
         // column saturates rather than wrapping
         col_in    = (col_sum > COL_MAX) ? COL_MAX[COL_W-1:0] : col_sum[COL_W-1:0];
         opaque_in = !opaque_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff <= 1'b1;
         opaque_ff <= 1'b0;
         col_ff    <= '0;
         row_ff    <= '0;
         base_ff   <= '0;
      end else if (advance) begin
         expect_ff <= expect_in;
         opaque_ff <= opaque_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         base_ff   <= base_in;
      end
   end

   // result register
   dst_type        dst_x_ff, dst_y_ff;
   src_offset_type src_ff;
   run_length_type len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= emit;
      end else if (rsp_run.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         dst_x_ff <= dst_x_in;
         dst_y_ff <= dst_y_in;
         src_ff   <= src_in;
         len_ff   <= len_in;
      end
   end

   assign rsp_run.valid      = out_valid_ff;
   assign rsp_run.dst_x      = dst_x_ff;
   assign rsp_run.dst_y      = dst_y_ff;
   assign rsp_run.src_offset = src_ff;
   assign rsp_run.run_length = len_ff;

`ifndef SYNTHESIS
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (len_ff != '0))
      else $error("result beat with empty run");

   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      {{(AW-COL_W){1'b0}}, col_ff} <= COL_MAX)
      else $error("column past saturation point");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      {{(NW-ROW_W){1'b0}}, row_ff} < ROW_LIMIT)
      else $error("row index out of range");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(word_ff)))
      else $error("stalled span word lost");

   a_row_end: assert property (@(posedge clock) disable iff (reset)
      (advance && !expect_ff && (word_ff == '0)) |=> (expect_ff && !out_valid_ff))
      else $error("row end did not rearm row start");
`endif

endmodule

[tb/ssrc_run_checker.sv]
`timescale 1ns / 1ps

module ssrc_run_checker
   import ssrc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   ssrc_req_if                    req_span,
   ssrc_rsp_if                    rsp_run,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output int                     mismatch_count,
   output int                     pending_runs
);

   localparam int ROW_LIMIT      = 1024;
   localparam int COLUMN_CEILING = 2 * ROW_LIMIT - 1;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      dst_type        dst_x;
      dst_type        dst_y;
      src_offset_type src_offset;
      run_length_type run_length;
   } run_beat_type;

   run_beat_type expected_runs [$];

   // register shadow
   logic [10:0] scr_w;
   logic [10:0] scr_h;
   logic [10:0] spr_w;
   logic [10:0] spr_h;
   logic [10:0] org_x;
   logic [10:0] org_y;
   logic        clip_on;

   // sprite walk state
   logic        awaiting_row_flag;
   logic        opaque_run;
   logic [10:0] column;
   logic [9:0]  row;
   logic [19:0] row_src_base;

   task automatic clip_span_word(input span_word_type word);
      int w;
      int px;
      int py;
      int c;
      int x;
      int y;
      int lo;
      int hi;
      int a;
      int b;
      int next_row;
      int base;
      run_beat_type beat;
      w = word;
      if (awaiting_row_flag) begin
         opaque_run        = (w == 1);
         column            = '0;
         awaiting_row_flag = 1'b0;
      end else if (w == 0) begin
         next_row = row;
         next_row = next_row + 1;
         if (next_row >= int'(spr_h) || next_row >= ROW_LIMIT) begin
            row          = '0;
            row_src_base = '0;
         end else begin
            row          = 10'(next_row);
            row_src_base = row_src_base + spr_w;
         end
         awaiting_row_flag = 1'b1;
      end else begin
         if (opaque_run) begin
            px   = $signed(org_x);
            py   = $signed(org_y);
            c    = column;
            base = row_src_base;
            x    = px + c;
            y    = py + int'(row);
            if (!clip_on) begin
               beat.dst_x      = dst_type'(x);
               beat.dst_y      = dst_type'(y);
               beat.src_offset = src_offset_type'(base + c);
               beat.run_length = run_length_type'((w > LEN_MAX) ? LEN_MAX : w);
               expected_runs.push_back(beat);
            end else if (y >= 0 && y < int'(scr_h)) begin
               // visible window is the screen cut by the sprite box
               lo = (px > 0) ? px : 0;
               hi = px + int'(spr_w);
               if (hi > int'(scr_w)) hi = scr_w;
               a = (x > lo) ? x : lo;
               b = x + w;
               if (b > hi) b = hi;
               if (a < b) begin
                  beat.dst_x      = dst_type'(a);
                  beat.dst_y      = dst_type'(y);
                  beat.src_offset = src_offset_type'(base + c + (a - x));
                  beat.run_length = run_length_type'(b - a);
                  expected_runs.push_back(beat);
               end
            end
         end
         c = column;
         c = c + w;
         column     = (c > COLUMN_CEILING) ? 11'(COLUMN_CEILING) : 11'(c);
         opaque_run = !opaque_run;
      end
   endtask

   always @(posedge clock) begin
      run_beat_type got;
      run_beat_type want;
      if (reset) begin
         scr_w             = RST_SCREEN_WIDTH;
         scr_h             = RST_SCREEN_HEIGHT;
         spr_w             = RST_SPRITE_WIDTH;
         spr_h             = RST_SPRITE_HEIGHT;
         org_x             = RST_POS_X;
         org_y             = RST_POS_Y;
         clip_on           = RST_CLIP_ENABLE;
         awaiting_row_flag = 1'b1;
         opaque_run        = 1'b0;
         column            = '0;
         row               = '0;
         row_src_base      = '0;
         mismatch_count    = 0;
         expected_runs.delete();
      end else begin
         // result beats come from older words, so check before predicting
         if (rsp_run.valid && rsp_run.ready) begin
            got.dst_x      = rsp_run.dst_x;
            got.dst_y      = rsp_run.dst_y;
            got.src_offset = rsp_run.src_offset;
            got.run_length = rsp_run.run_length;
            if (expected_runs.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%t unexpected run beat: dst_x %0d dst_y %0d src %0d len %0d",
                           $realtime, $signed(got.dst_x), $signed(got.dst_y),
                           got.src_offset, got.run_length);
            end else begin
               want = expected_runs.pop_front();
               if (got.dst_x !== want.dst_x || got.dst_y !== want.dst_y ||
                   got.src_offset !== want.src_offset ||
                   got.run_length !== want.run_length) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"%t run beat mismatch: exp x %0d y %0d src %0d len %0d,",
                               " got x %0d y %0d src %0d len %0d"},
                              $realtime, $signed(want.dst_x), $signed(want.dst_y),
                              want.src_offset, want.run_length, $signed(got.dst_x),
                              $signed(got.dst_y), got.src_offset, got.run_length);
               end
            end
         end
         if (req_span.valid && req_span.ready)
            clip_span_word(req_span.span_word);
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:  scr_w   = csr_write_data;
               CSR_SCREEN_HEIGHT: scr_h   = csr_write_data;
               CSR_SPRITE_WIDTH:  spr_w   = csr_write_data;
               CSR_SPRITE_HEIGHT: spr_h   = csr_write_data;
               CSR_POS_X:         org_x   = csr_write_data;
               CSR_POS_Y:         org_y   = csr_write_data;
               CSR_CLIP_ENABLE:   clip_on = csr_write_data[0];
               default: ;
            endcase
         end
      end
      pending_runs = expected_runs.size();
   end

endmodule

[tb/tb_sprite_span_run_clipper.sv]
`timescale 1ns / 1ps

module tb_sprite_span_run_clipper;
   import ssrc_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 4;
   localparam int SEGMENT_WORDS = 195;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   int mismatch_count;
   int pending_runs;
   int cycle_count = 0;
   int send_idle_pct;
   int recv_idle_pct;

   // screen w, screen h, sprite w, sprite h, pos x, pos y, clip
   int csr_plan [11][7] = '{
      '{320, 240, 40, 2, -10, -1, 1},
      '{2047, 2047, 2047, 0, 1023, -1024, 0},
      '{320, 240, 64, 16, -20, -4, 1},
      '{1024, 1024, 1024, 1024, 1023, 1023, 1},
      '{1, 1, 1, 1, 0, 0, 1},
      '{64, 48, 100, 30, -1024, -1024, 0},
      '{2047, 2047, 2047, 3, -512, 100, 0},
      '{300, 200, 0, 0, 20, 20, 0},
      '{0, 0, 17, 5, 3, 3, 1},
      '{640, 480, 96, 64, 600, 470, 1},
      '{200, 100, 64, 0, 5, -2, 1}
   };

   // off-screen row, partial runs at both sprite edges, row wrap
   span_word_type clipped_rows [12] = '{
      16'd1, 16'd15, 16'd0,
      16'd1, 16'd15, 16'd10, 16'd30, 16'd0,
      16'd0, 16'd5, 16'd7, 16'd0
   };

   // long runs, column saturation, position wrap, odd row flags
   span_word_type wide_rows [9] = '{
      16'd1, 16'hFFFF, 16'h8000, 16'd3, 16'd0,
      16'hAAAA, 16'h5555, 16'd1, 16'd0
   };

   ssrc_req_if req_span ();
   ssrc_rsp_if rsp_run ();

   sprite_span_run_clipper i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_span         (req_span),
      .rsp_run          (rsp_run),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   ssrc_run_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_span         (req_span),
      .rsp_run          (rsp_run),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .pending_runs     (pending_runs)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_run.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_word(input span_word_type word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_span.valid <= 1'b0;
         @(negedge clock);
      end
      req_span.valid     <= 1'b1;
      req_span.span_word <= word;
      do @(posedge clock); while (!req_span.ready);
      @(negedge clock);
   endtask

   task automatic drain_runs();
      req_span.valid <= 1'b0;
      while (pending_runs != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input int value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= CSR_DATA_W'(value);
      @(negedge clock);
   endtask

   task automatic reconfigure(input int vals [7]);
      drain_runs();
      write_reg(CSR_SCREEN_WIDTH, vals[0]);
      write_reg(CSR_SCREEN_HEIGHT, vals[1]);
      write_reg(CSR_SPRITE_WIDTH, vals[2]);
      write_reg(CSR_SPRITE_HEIGHT, vals[3]);
      write_reg(CSR_POS_X, vals[4]);
      write_reg(CSR_POS_Y, vals[5]);
      write_reg(CSR_CLIP_ENABLE, vals[6]);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_sprite_rows(input int word_count);
      int sent;
      int runs;
      int pick;
      span_word_type word;
      sent = 0;
      while (sent < word_count) begin
         pick = $urandom_range(99);
         if (pick < 45) word = 16'd1;
         else if (pick < 80) word = 16'd0;
         else word = span_word_type'($urandom_range(0, 65535));
         send_word(word);
         runs = $urandom_range(0, 6);
         for (int k = 0; k < runs; k++) begin
            pick = $urandom_range(99);
            if (pick < 65) word = span_word_type'($urandom_range(1, 20));
            else if (pick < 88) word = span_word_type'($urandom_range(1, 400));
            else if (pick < 97) word = span_word_type'($urandom_range(300, 2200));
            else word = span_word_type'($urandom_range(1, 65535));
            send_word(word);
         end
         // now and then a row runs on without its end word
         if ($urandom_range(9) != 0) begin
            send_word('0);
            sent++;
         end
         sent += runs + 1;
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_span.valid     = 1'b0;
      req_span.span_word = '0;
      csr_write_enable   = 1'b0;
      csr_index          = '0;
      csr_write_data     = '0;
      send_idle_pct      = 32;
      recv_idle_pct      = 68;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      reconfigure(csr_plan[0]);
      foreach (clipped_rows[i]) send_word(clipped_rows[i]);
      reconfigure(csr_plan[1]);
      foreach (wide_rows[i]) send_word(wide_rows[i]);

      for (int seg = 0; seg < 9; seg++) begin
         reconfigure(csr_plan[seg + 2]);
         if (seg == 3) begin
            send_idle_pct = 68;
            recv_idle_pct = 32;
         end
         if (seg == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_sprite_rows(SEGMENT_WORDS);
      end

      drain_runs();
      if (mismatch_count == 0 && pending_runs == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

[files.f]
rtl/ssrc_pkg.sv
rtl/ssrc_if.sv
rtl/sprite_span_run_clipper.sv
tb/ssrc_run_checker.sv
tb/tb_sprite_span_run_clipper.sv
